// ===== hdl/crc16fr_pkg.sv =====
// Shared constants, command/status types and CRC helper for the CRC-16 frame receiver.
`default_nettype none
package crc16fr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEAD_RESET    = 8'h55;
  localparam logic [7:0] VERSION_RESET = 8'h01;

  localparam logic REG_HEAD    = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  typedef struct packed {
    logic crc_init;
    logic crc_feed;
    logic cap_cmd;
    logic cap_seq;
    logic cap_len;
    logic cap_lo;
    logic wr_payload;
    logic clr_fill;
    logic emit_start;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_hit;
    logic ver_hit;
    logic len_big;
    logic rx_zero;
    logic len_zero;
    logic fill_done;
    logic crc_ok;
    logic emit_last;
    logic has_data;
  } dp_status_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/crc16_frame_receiver.sv =====
// Top level: CRC-16/Modbus framed packet receiver with APB-style configuration.
// Results: a matching frame's first result shows after the payload RAM read once the
// CRC high byte is taken (an empty frame goes straight to output); each further payload
// result follows once the previous one is taken (payload RAM read, then output).
// Throughput: one byte per cycle while parsing; input stalls during the result run.
// Reset: synchronous, rst_n low; hunt for head, head 0x55, version 0x01, payload RAM kept.
`default_nettype none
module crc16_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_frame_cmd,
  output logic [7:0]       out_frame_seq,
  output logic [5:0]       out_frame_length,
  output logic [4:0]       out_byte_index,
  output logic [7:0]       out_data_byte,
  output logic             out_has_data,
  output logic             out_last
);
  import crc16fr_pkg::*;

  logic [7:0] head_r, version_r;
  logic       cfg_we;
  logic       accepting, out_busy;
  logic       in_fire, out_fire;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= HEAD_RESET;
      version_r <= VERSION_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_HEAD:    head_r    <= pwdata[7:0];
        REG_VERSION: version_r <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEAD:    prdata = {24'h0, head_r};
      REG_VERSION: prdata = {24'h0, version_r};
      default:     prdata = '0;
    endcase
  end

  assign in_stall  = ~accepting;
  assign in_fire   = in_valid & accepting;
  assign out_valid = out_busy;
  assign out_fire  = out_busy & ~out_stall;

  crc16fr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .status    (status),
    .cmd       (cmd),
    .accepting (accepting),
    .out_busy  (out_busy)
  );

  crc16fr_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_rx_byte),
    .head_byte    (head_r),
    .version_byte (version_r),
    .cmd          (cmd),
    .status       (status),
    .frame_cmd    (out_frame_cmd),
    .frame_seq    (out_frame_seq),
    .frame_length (out_frame_length),
    .byte_index   (out_byte_index),
    .data_byte    (out_data_byte),
    .has_data     (out_has_data),
    .last         (out_last)
  );

endmodule
`default_nettype wire

// ===== hdl/crc16fr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crc16fr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/crc16fr_datapath.sv =====
// Datapath: header capture, running CRC, payload store and result fields.
`default_nettype none
module crc16fr_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [7:0]              rx_byte,
  input  wire logic [7:0]              head_byte,
  input  wire logic [7:0]              version_byte,
  input  wire crc16fr_pkg::ctrl_cmd_t  cmd,
  output crc16fr_pkg::dp_status_t      status,
  output logic [7:0]                   frame_cmd,
  output logic [7:0]                   frame_seq,
  output logic [5:0]                   frame_length,
  output logic [4:0]                   byte_index,
  output logic [7:0]                   data_byte,
  output logic                         has_data,
  output logic                         last
);
  import crc16fr_pkg::*;

  logic [7:0]        cmd_r, seq_r, lo_r;
  logic [LEN_W-1:0]  len_r, fill_r;
  logic [15:0]       crc_r, crc_nxt;
  logic [ADDR_W-1:0] idx_r, raddr;
  logic              has_data_r;
  logic [7:0]        rdata;
  logic              re;

  assign crc_nxt = crc_step(cmd.crc_init ? CRC_INIT : crc_r, rx_byte);
  assign raddr   = cmd.emit_start ? '0 : idx_r + ADDR_W'(1);
  assign re      = cmd.emit_start | cmd.emit_next;

  crc16fr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_payload),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= '0;
      seq_r      <= '0;
      lo_r       <= '0;
      len_r      <= '0;
      fill_r     <= '0;
      crc_r      <= CRC_INIT;
      idx_r      <= '0;
      has_data_r <= 1'b0;
    end else begin
      if (cmd.crc_init || cmd.crc_feed) crc_r <= crc_nxt;
      if (cmd.cap_cmd) cmd_r <= rx_byte;
      if (cmd.cap_seq) seq_r <= rx_byte;
      if (cmd.cap_len) len_r <= rx_byte[LEN_W-1:0];
      if (cmd.cap_lo)  lo_r  <= rx_byte;
      if (cmd.clr_fill) fill_r <= '0;
      else if (cmd.wr_payload) fill_r <= fill_r + LEN_W'(1);
      if (cmd.emit_start) begin
        idx_r      <= '0;
        has_data_r <= (len_r != '0);
      end else if (cmd.emit_next) begin
        idx_r <= idx_r + ADDR_W'(1);
      end
    end
  end

  always_comb begin
    status.head_hit  = (rx_byte == head_byte);
    status.ver_hit   = (rx_byte == version_byte);
    status.len_big   = (rx_byte > 8'(MAX_PAYLOAD));
    status.rx_zero   = (rx_byte == 8'h00);
    status.len_zero  = (len_r == '0);
    status.fill_done = ((fill_r + LEN_W'(1)) >= len_r);
    status.crc_ok    = ({rx_byte, lo_r} == crc_r);
    status.emit_last = ((LEN_W'(idx_r) + LEN_W'(1)) == len_r);
    status.has_data  = has_data_r;
  end

  assign frame_cmd    = cmd_r;
  assign frame_seq    = seq_r;
  assign frame_length = has_data_r ? len_r : '0;
  assign byte_index   = idx_r;
  assign data_byte    = has_data_r ? rdata : 8'h00;
  assign has_data     = has_data_r;
  assign last         = has_data_r ? status.emit_last : 1'b1;

endmodule
`default_nettype wire

// ===== hdl/crc16fr_ctrl.sv =====
// Controller: frame parse state machine and result run sequencing.
`default_nettype none
module crc16fr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_fire,
  input  wire logic                    out_fire,
  input  wire crc16fr_pkg::dp_status_t status,
  output crc16fr_pkg::ctrl_cmd_t       cmd,
  output logic                         accepting,
  output logic                         out_busy
);
  import crc16fr_pkg::*;

  localparam logic [3:0] ST_HEAD    = 4'd0;
  localparam logic [3:0] ST_VERSION = 4'd1;
  localparam logic [3:0] ST_CMD     = 4'd2;
  localparam logic [3:0] ST_SEQ     = 4'd3;
  localparam logic [3:0] ST_LEN     = 4'd4;
  localparam logic [3:0] ST_PAYLOAD = 4'd5;
  localparam logic [3:0] ST_CRCLO   = 4'd6;
  localparam logic [3:0] ST_CRCHI   = 4'd7;
  localparam logic [3:0] ST_EMIT_RD = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign accepting = (state_r != ST_EMIT_RD) && (state_r != ST_EMIT);
  assign out_busy  = (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HEAD: begin
        if (in_fire && status.head_hit) state_nxt = ST_VERSION;
      end
      ST_VERSION: begin
        if (in_fire) begin
          if (status.ver_hit) begin
            cmd.crc_init = 1'b1;
            state_nxt    = ST_CMD;
          end else begin
            cmd.clr_fill = 1'b1;
            state_nxt    = ST_HEAD;
          end
        end
      end
      ST_CMD: begin
        if (in_fire) begin
          cmd.cap_cmd  = 1'b1;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_SEQ;
        end
      end
      ST_SEQ: begin
        if (in_fire) begin
          cmd.cap_seq  = 1'b1;
          cmd.crc_feed = 1'b1;
          state_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          cmd.clr_fill = 1'b1;
          if (status.len_big) begin
            state_nxt = ST_HEAD;
          end else begin
            cmd.cap_len  = 1'b1;
            cmd.crc_feed = 1'b1;
            state_nxt    = status.rx_zero ? ST_CRCLO : ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          cmd.wr_payload = 1'b1;
          cmd.crc_feed   = 1'b1;
          if (status.fill_done) state_nxt = ST_CRCLO;
        end
      end
      ST_CRCLO: begin
        if (in_fire) begin
          cmd.cap_lo = 1'b1;
          state_nxt  = ST_CRCHI;
        end
      end
      ST_CRCHI: begin
        if (in_fire) begin
          cmd.clr_fill = 1'b1;
          if (status.crc_ok) begin
            cmd.emit_start = 1'b1;
            state_nxt      = status.len_zero ? ST_EMIT : ST_EMIT_RD;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (status.has_data && !status.emit_last) begin
            cmd.emit_next = 1'b1;
            state_nxt     = ST_EMIT_RD;
          end else begin
            state_nxt = ST_HEAD;
          end
        end
      end
      default: begin
        if (in_fire) begin
          cmd.clr_fill = 1'b1;
          state_nxt    = ST_HEAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_HEAD;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the CRC-16 frame receiver: scoreboard class, byte and frame drivers, result sink.
`timescale 1ns / 1ps
module testbench;
  import crc16fr_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int BYTES_PER_SET = 75;

  typedef enum logic [2:0] {
    P_HUNT, P_VERSION, P_CMD, P_SEQ, P_LENGTH, P_PAYLOAD, P_CRC_LO, P_CRC_HI
  } parse_phase_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_BAD_VER, FRAME_TOO_LONG} frame_kind_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] seq;
    logic [5:0] length;
    logic [4:0] index;
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } frame_beat_t;

  class frame_scoreboard;
    logic [7:0]   head_val;
    logic [7:0]   version_val;
    parse_phase_t phase;
    logic [7:0]   cmd_q;
    logic [7:0]   seq_q;
    logic [5:0]   len_q;
    logic [7:0]   payload_mem[MAX_PAYLOAD];
    logic [5:0]   fill;
    logic [7:0]   crc_lo_q;
    logic [15:0]  crc_acc;
    frame_beat_t  beats_due[$];
    int           mismatches;
    int           frames_out;
    int           beats_checked;

    function new();
      head_val      = HEAD_RESET;
      version_val   = VERSION_RESET;
      phase         = P_HUNT;
      cmd_q         = '0;
      seq_q         = '0;
      len_q         = '0;
      fill          = '0;
      crc_lo_q      = '0;
      crc_acc       = CRC_INIT;
      mismatches    = 0;
      frames_out    = 0;
      beats_checked = 0;
    endfunction

    static function logic [15:0] fold_crc(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void set_register(logic idx, logic [7:0] v);
      if (idx == REG_HEAD) head_val = v;
      else version_val = v;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void note_input(logic [7:0] b);
      frame_beat_t beat;
      case (phase)
        P_HUNT: if (b == head_val) phase = P_VERSION;
        P_VERSION: begin
          if (b == version_val) begin
            crc_acc = fold_crc(CRC_INIT, b);
            phase   = P_CMD;
          end else begin
            phase = P_HUNT;
            fill  = '0;
          end
        end
        P_CMD: begin
          cmd_q   = b;
          crc_acc = fold_crc(crc_acc, b);
          phase   = P_SEQ;
        end
        P_SEQ: begin
          seq_q   = b;
          crc_acc = fold_crc(crc_acc, b);
          phase   = P_LENGTH;
        end
        P_LENGTH: begin
          fill = '0;
          if (b > MAX_PAYLOAD) begin
            phase = P_HUNT;
          end else begin
            len_q   = b[5:0];
            crc_acc = fold_crc(crc_acc, b);
            phase   = (b == 0) ? P_CRC_LO : P_PAYLOAD;
          end
        end
        P_PAYLOAD: begin
          if (fill < MAX_PAYLOAD) payload_mem[fill[4:0]] = b;
          fill    = fill + 1'b1;
          crc_acc = fold_crc(crc_acc, b);
          if (fill >= len_q) phase = P_CRC_LO;
        end
        P_CRC_LO: begin
          crc_lo_q = b;
          phase    = P_CRC_HI;
        end
        default: begin
          if ({b, crc_lo_q} == crc_acc) begin
            frames_out++;
            if (len_q == 0) begin
              beat = '{cmd: cmd_q, seq: seq_q, length: '0, index: '0, data: '0,
                       has_data: 1'b0, last: 1'b1};
              beats_due.push_back(beat);
            end else begin
              for (int k = 0; k < len_q; k++) begin
                beat = '{cmd: cmd_q, seq: seq_q, length: len_q, index: k[4:0],
                         data: payload_mem[k], has_data: 1'b1, last: (k + 1 == len_q)};
                beats_due.push_back(beat);
              end
            end
          end
          phase = P_HUNT;
          fill  = '0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(frame_beat_t got);
      frame_beat_t want;
      beats_checked++;
      if (beats_due.size() == 0) begin
        $error("unexpected result: cmd %0h seq %0h index %0d", got.cmd, got.seq, got.index);
        mismatches++;
        return;
      end
      want = beats_due.pop_front();
      compare_field("frame_cmd", want.cmd, got.cmd);
      compare_field("frame_seq", want.seq, got.seq);
      compare_field("frame_length", {2'b0, want.length}, {2'b0, got.length});
      compare_field("byte_index", {3'b0, want.index}, {3'b0, got.index});
      compare_field("data_byte", want.data, got.data);
      compare_field("has_data", {7'b0, want.has_data}, {7'b0, got.has_data});
      compare_field("last", {7'b0, want.last}, {7'b0, got.last});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_frame_cmd;
  logic [7:0]  out_frame_seq;
  logic [5:0]  out_frame_length;
  logic [4:0]  out_byte_index;
  logic [7:0]  out_data_byte;
  logic        out_has_data;
  logic        out_last;

  frame_scoreboard sb = new();
  logic [7:0] head_cur    = HEAD_RESET;
  logic [7:0] version_cur = VERSION_RESET;
  int         bytes_sent  = 0;
  int         send_calm   = 0;
  int         settings_used = 1;
  bit         hold_armed  = 1'b0;
  int         cycle_count = 0;

  crc16_frame_receiver i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_cmd   (out_frame_cmd),
    .out_frame_seq   (out_frame_seq),
    .out_frame_length(out_frame_length),
    .out_byte_index  (out_byte_index),
    .out_data_byte   (out_data_byte),
    .out_has_data    (out_has_data),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind, input logic [7:0] cmd,
                            input logic [7:0] seq, input int len, input int fill);
    logic [7:0]  bytes_q[$];
    logic [7:0]  flip;
    logic [15:0] crc;
    bytes_q.push_back(head_cur);
    if (kind == FRAME_BAD_VER) begin
      flip = 8'h01 << $urandom_range(0, 7);
      bytes_q.push_back(version_cur ^ flip);
    end else begin
      bytes_q.push_back(version_cur);
      bytes_q.push_back(cmd);
      bytes_q.push_back(seq);
      bytes_q.push_back(8'(len));
      if (kind != FRAME_TOO_LONG) begin
        for (int k = 0; k < len; k++)
          bytes_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        crc = CRC_INIT;
        for (int k = 1; k < bytes_q.size(); k++) crc = frame_scoreboard::fold_crc(crc, bytes_q[k]);
        if (kind == FRAME_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
      end
    end
    foreach (bytes_q[k]) send_byte(bytes_q[k]);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, v);
    if (idx == REG_HEAD) head_cur = v;
    else version_cur = v;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 32);
    if ($urandom_range(0, 19) == 0) len = MAX_PAYLOAD;
    if (pick < 66) begin
      send_frame(FRAME_GOOD, 8'($urandom), 8'($urandom), len, -1);
    end else if (pick < 76) begin
      send_frame(FRAME_BAD_CRC, 8'($urandom), 8'($urandom), len, -1);
    end else if (pick < 84) begin
      send_frame(FRAME_BAD_VER, 8'h00, 8'h00, 0, -1);
    end else if (pick < 90) begin
      send_frame(FRAME_TOO_LONG, 8'($urandom), 8'($urandom),
                 $urandom_range(MAX_PAYLOAD + 1, 255), -1);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end
  endtask

  initial begin : result_sink
    int          stall_left;
    int          calm_left;
    frame_beat_t beat;
    stall_left = 0;
    calm_left  = 0;
    out_stall <= 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        beat = '{cmd: out_frame_cmd, seq: out_frame_seq, length: out_frame_length,
                 index: out_byte_index, data: out_data_byte, has_data: out_has_data,
                 last: out_last};
        sb.check_result(beat);
        stall_left = draw_gap(calm_left);
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] head_set[4];
    logic [7:0] version_set[4];
    int target;
    rst_n      <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(FRAME_GOOD, 8'hFF, 8'h00, 0, -1);
    send_frame(FRAME_GOOD, 8'h00, 8'hFF, 1, 8'hFF);
    send_frame(FRAME_BAD_VER, 8'h00, 8'h00, 0, -1);
    send_frame(FRAME_TOO_LONG, 8'h12, 8'h34, MAX_PAYLOAD + 1, -1);

    head_set    = '{8'hFF, 8'h00, 8'($urandom), HEAD_RESET};
    version_set = '{8'h00, 8'hFF, 8'($urandom), VERSION_RESET};
    for (int s = 0; s < 4; s++) begin
      wait_drained();
      write_reg(REG_HEAD, head_set[s]);
      write_reg(REG_VERSION, version_set[s]);
      settings_used++;
      if (s == 0) hold_armed = 1'b1;
      target = bytes_sent + BYTES_PER_SET;
      while (bytes_sent < target) random_frame();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d bytes over %0d register settings, incl. a long output hold-off",
             bytes_sent, settings_used);
    $display("%0d frames delivered, %0d result beats checked", sb.frames_out, sb.beats_checked);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
